/* rtl/lap_pkg.sv */
// -----------------------------------------------------------------------------
// lap_pkg: shared types and constants of the link adaptation policy
// Word types, register codes, tier table and fixed-point limits.
// -----------------------------------------------------------------------------
package lap_pkg;

   // configuration register codes
   typedef enum logic [2:0] {
      REG_MODEL_BIAS       = 3'd0,
      REG_WEIGHT_SNR       = 3'd1,
      REG_WEIGHT_SCINT     = 3'd2,
      REG_WEIGHT_BER       = 3'd3,
      REG_WEIGHT_TURBIDITY = 3'd4,
      REG_LOW_BATTERY_MV   = 3'd5
   } lap_reg_type;

   typedef enum logic [1:0] {
      MOD_OOK  = 2'd0,
      MOD_PPM2 = 2'd1,
      MOD_PPM4 = 2'd2
   } lap_mod_type;

   typedef enum logic [1:0] {
      RATE_1M = 2'd0,
      RATE_2M = 2'd1,
      RATE_5M = 2'd2
   } lap_rate_type;

   typedef enum logic [1:0] {
      TIER_BEST = 2'd0,
      TIER_GOOD = 2'd1,
      TIER_FAIR = 2'd2,
      TIER_POOR = 2'd3
   } lap_tier_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;
   localparam int SUM_W       = 31;

   typedef struct packed {
      logic signed [15:0] snr_db;
      logic [19:0]        ber_ppm;
      logic [15:0]        turbidity;
      logic [15:0]        scint_index;
      logic [12:0]        battery_mv;
   } lap_req_type;

   typedef struct packed {
      logic [1:0]  link_tier;
      logic [1:0]  modulation;
      logic [1:0]  sym_rate;
      logic [3:0]  tx_power;
      logic [2:0]  rx_gain;
      logic [15:0] detect_threshold;
   } lap_rsp_type;

   typedef struct packed {
      logic signed [16:0] model_bias;
      logic signed [15:0] weight_snr;
      logic signed [16:0] weight_scint;
      logic signed [15:0] weight_ber;
      logic signed [15:0] weight_turbidity;
      logic [12:0]        low_battery_mv;
   } lap_cfg_type;

   localparam lap_cfg_type CFG_RESET = '{
      model_bias:       -17'sd1442,
      weight_snr:       -16'sd786,
      weight_scint:     17'sd27525,
      weight_ber:       16'sd4362,
      weight_turbidity: 16'sd1966,
      low_battery_mv:   13'd3350
   };

   // tier thresholds (SNR in 1/256 dB, turbidity in 1/256 NTU)
   localparam logic signed [15:0] SNR_TIER0 = 16'sd5120;
   localparam logic signed [15:0] SNR_TIER1 = 16'sd3584;
   localparam logic signed [15:0] SNR_TIER2 = 16'sd2048;
   localparam logic [19:0]        BER_TIER0 = 20'd100;
   localparam logic [19:0]        BER_TIER1 = 20'd500;
   localparam logic [19:0]        BER_TIER2 = 20'd2000;
   localparam logic [15:0]        TURB_TIER0 = 16'd512;

   localparam logic [3:0] POWER_CAP = 4'd8;

   // threshold limits, Q16
   localparam logic signed [SUM_W-1:0] DELTA_MAX   = 31'sd19661;
   localparam logic signed [SUM_W-1:0] DELTA_MIN   = -31'sd19661;
   localparam logic signed [16:0]      THRESH_HALF = 17'sd32768;
   localparam logic signed [16:0]      THRESH_MIN  = 17'sd9830;
   localparam logic signed [16:0]      THRESH_MAX  = 17'sd55706;

   function automatic lap_mod_type tier_mod(input lap_tier_type tier);
      case (tier)
         TIER_BEST: tier_mod = MOD_OOK;
         TIER_GOOD: tier_mod = MOD_PPM2;
         default:   tier_mod = MOD_PPM4;
      endcase
   endfunction

   function automatic lap_rate_type tier_rate(input lap_tier_type tier);
      case (tier)
         TIER_BEST: tier_rate = RATE_5M;
         TIER_GOOD: tier_rate = RATE_2M;
         TIER_FAIR: tier_rate = RATE_2M;
         default:   tier_rate = RATE_1M;
      endcase
   endfunction

   function automatic logic [3:0] tier_power(input lap_tier_type tier);
      case (tier)
         TIER_BEST: tier_power = 4'd2;
         TIER_GOOD: tier_power = 4'd5;
         TIER_FAIR: tier_power = 4'd8;
         default:   tier_power = 4'd12;
      endcase
   endfunction

   function automatic logic [2:0] tier_gain(input lap_tier_type tier);
      case (tier)
         TIER_BEST: tier_gain = 3'd1;
         TIER_GOOD: tier_gain = 3'd2;
         TIER_FAIR: tier_gain = 3'd4;
         default:   tier_gain = 3'd6;
      endcase
   endfunction

endpackage

/* rtl/lap_if.sv */
// -----------------------------------------------------------------------------
// lap_if: channel interfaces of the link adaptation policy
// Measurement channel, setting channel and register write channel.
// -----------------------------------------------------------------------------
interface lap_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] snr_db;
   logic [19:0]        ber_ppm;
   logic [15:0]        turbidity;
   logic [15:0]        scint_index;
   logic [12:0]        battery_mv;

   modport source (output valid, snr_db, ber_ppm, turbidity, scint_index, battery_mv,
                   input ready);
   modport sink (input valid, snr_db, ber_ppm, turbidity, scint_index, battery_mv,
                 output ready);
endinterface

interface lap_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  link_tier;
   logic [1:0]  modulation;
   logic [1:0]  sym_rate;
   logic [3:0]  tx_power;
   logic [2:0]  rx_gain;
   logic [15:0] detect_threshold;

   modport source (output valid, link_tier, modulation, sym_rate, tx_power,
                   rx_gain, detect_threshold, input ready);
   modport sink (input valid, link_tier, modulation, sym_rate, tx_power,
                 rx_gain, detect_threshold, output ready);
endinterface

interface lap_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lap_pkg::CSR_INDEX_W-1:0] index;
   logic [lap_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/lap_policy_core.sv */
// -----------------------------------------------------------------------------
// lap_policy_core: tier decision and detection threshold
// Combinational: one measurement word and the registers in, one setting out.
// -----------------------------------------------------------------------------
module lap_policy_core (
   input  lap_pkg::lap_req_type req,
   input  lap_pkg::lap_cfg_type cfg,
   output lap_pkg::lap_rsp_type rsp
);

   lap_pkg::lap_tier_type   tier;
   lap_pkg::lap_rate_type   rate;
   logic [3:0]              power;

   logic signed [31:0]      prod_snr;
   logic signed [33:0]      prod_scint;
   logic signed [36:0]      prod_ber;
   logic signed [32:0]      prod_turb;
   logic signed [lap_pkg::SUM_W-1:0] sum;
   logic signed [lap_pkg::SUM_W-1:0] delta;
   logic signed [16:0]      thr_raw;
   logic signed [16:0]      thr;

   always_comb begin
      if (req.snr_db > lap_pkg::SNR_TIER0 && req.ber_ppm < lap_pkg::BER_TIER0 &&
          req.turbidity < lap_pkg::TURB_TIER0) begin
         tier = lap_pkg::TIER_BEST;
      end else if (req.snr_db > lap_pkg::SNR_TIER1 && req.ber_ppm < lap_pkg::BER_TIER1) begin
         tier = lap_pkg::TIER_GOOD;
      end else if (req.snr_db > lap_pkg::SNR_TIER2 && req.ber_ppm < lap_pkg::BER_TIER2) begin
         tier = lap_pkg::TIER_FAIR;
      end else begin
         tier = lap_pkg::TIER_POOR;
      end
   end

   // low battery with power above the cap: cap power and drop to the slowest rate
   always_comb begin
      rate  = lap_pkg::tier_rate(tier);
      power = lap_pkg::tier_power(tier);
      if (req.battery_mv < cfg.low_battery_mv && power > lap_pkg::POWER_CAP) begin
         power = lap_pkg::POWER_CAP;
         rate  = lap_pkg::RATE_1M;
      end
   end

   // unsigned measurements enter the products with a zero sign bit
   assign prod_snr   = cfg.weight_snr * req.snr_db;
   assign prod_scint = cfg.weight_scint * $signed({1'b0, req.scint_index});
   assign prod_ber   = cfg.weight_ber * $signed({1'b0, req.ber_ppm});
   assign prod_turb  = cfg.weight_turbidity * $signed({1'b0, req.turbidity});

   assign sum = lap_pkg::SUM_W'(cfg.model_bias)
              + lap_pkg::SUM_W'(prod_snr >>> 8)
              + lap_pkg::SUM_W'(prod_scint >>> 15)
              + lap_pkg::SUM_W'(prod_ber >>> 8)
              + lap_pkg::SUM_W'(prod_turb >>> 8);

   always_comb begin
      if (sum > lap_pkg::DELTA_MAX) begin
         delta = lap_pkg::DELTA_MAX;
      end else if (sum < lap_pkg::DELTA_MIN) begin
         delta = lap_pkg::DELTA_MIN;
      end else begin
         delta = sum;
      end
   end

   assign thr_raw = lap_pkg::THRESH_HALF + 17'(delta);

   always_comb begin
      if (thr_raw < lap_pkg::THRESH_MIN) begin
         thr = lap_pkg::THRESH_MIN;
      end else if (thr_raw > lap_pkg::THRESH_MAX) begin
         thr = lap_pkg::THRESH_MAX;
      end else begin
         thr = thr_raw;
      end
   end

   always_comb begin
      rsp.link_tier        = tier;
      rsp.modulation       = lap_pkg::tier_mod(tier);
      rsp.sym_rate         = rate;
      rsp.tx_power         = power;
      rsp.rx_gain          = lap_pkg::tier_gain(tier);
      rsp.detect_threshold = thr[15:0];
   end

endmodule

/* rtl/link_adaptation_policy.sv */
// -----------------------------------------------------------------------------
// link_adaptation_policy: optical link transmit setting from measurements
// Takes one measurement word a cycle and returns one setting word for each,
// in order. A word is held in the input register while the tier compares,
// the four model products and the threshold clamps are worked out, then
// lands in the result register when that register is free or its word is
// taken, and rsp valid rises with it. Throughput is one word per clock as
// long as the result side takes its words. The result register parts the
// two sides, so a new word is taken while a finished one waits. The user
// must write registers through csr_bus only while the block holds no word;
// the block itself does not enforce this. Writes to unused indexes are
// dropped.
// -----------------------------------------------------------------------------
module link_adaptation_policy (
   input  logic         clock,
   input  logic         reset,
   lap_req_if.sink      req_bus,
   lap_rsp_if.source    rsp_bus,
   lap_csr_if.sink      csr_bus
);

   lap_pkg::lap_cfg_type cfg_ff;
   lap_pkg::lap_cfg_type cfg_in;
   lap_pkg::lap_req_type in_word_ff;
   lap_pkg::lap_rsp_type rsp_word_ff;
   lap_pkg::lap_rsp_type core_rsp;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 adv_out;
   logic                 adv_in;

   // ---- register file ----
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (lap_pkg::lap_reg_type'(csr_bus.index))
            lap_pkg::REG_MODEL_BIAS:       cfg_in.model_bias       = csr_bus.data;
            lap_pkg::REG_WEIGHT_SNR:       cfg_in.weight_snr       = csr_bus.data[15:0];
            lap_pkg::REG_WEIGHT_SCINT:     cfg_in.weight_scint     = csr_bus.data;
            lap_pkg::REG_WEIGHT_BER:       cfg_in.weight_ber       = csr_bus.data[15:0];
            lap_pkg::REG_WEIGHT_TURBIDITY: cfg_in.weight_turbidity = csr_bus.data[15:0];
            lap_pkg::REG_LOW_BATTERY_MV:   cfg_in.low_battery_mv   = csr_bus.data[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lap_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- pipeline control ----
   assign adv_out       = !rsp_valid_ff || rsp_bus.ready;
   assign adv_in        = !in_valid_ff || adv_out;
   assign req_bus.ready = adv_in;

   always_comb begin
      in_valid_in  = adv_in ? req_bus.valid : in_valid_ff;
      rsp_valid_in = adv_out ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- payload ----
   always_ff @(posedge clock) begin
      if (adv_in && req_bus.valid) begin
         in_word_ff.snr_db      <= req_bus.snr_db;
         in_word_ff.ber_ppm     <= req_bus.ber_ppm;
         in_word_ff.turbidity   <= req_bus.turbidity;
         in_word_ff.scint_index <= req_bus.scint_index;
         in_word_ff.battery_mv  <= req_bus.battery_mv;
      end
      if (adv_out && in_valid_ff) begin
         rsp_word_ff <= core_rsp;
      end
   end

   lap_policy_core u_core (
      .req (in_word_ff),
      .cfg (cfg_ff),
      .rsp (core_rsp)
   );

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.link_tier        = rsp_word_ff.link_tier;
   assign rsp_bus.modulation       = rsp_word_ff.modulation;
   assign rsp_bus.sym_rate         = rsp_word_ff.sym_rate;
   assign rsp_bus.tx_power         = rsp_word_ff.tx_power;
   assign rsp_bus.rx_gain          = rsp_word_ff.rx_gain;
   assign rsp_bus.detect_threshold = rsp_word_ff.detect_threshold;

endmodule

/* rtl/lap_checker.sv */
// -----------------------------------------------------------------------------
// lap_checker: port-level checks of the link adaptation policy
// Watches the request and result channels; bound to the top level.
// -----------------------------------------------------------------------------
module lap_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  link_tier,
   input logic [1:0]  modulation,
   input logic [1:0]  sym_rate,
   input logic [3:0]  tx_power,
   input logic [2:0]  rx_gain,
   input logic [15:0] detect_threshold
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(link_tier) &&
         $stable(modulation) && $stable(sym_rate) && $stable(tx_power) &&
         $stable(rx_gain) && $stable(detect_threshold))
      else $error("lap: stalled result word changed");

   // an accepted word shows up at the output when the output drains
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready |=> rsp_valid)
      else $error("lap: accepted word did not reach the output");

   // threshold stays inside its clamp window
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> detect_threshold >= 16'd9830 && detect_threshold <= 16'd55706)
      else $error("lap: threshold out of range");

   // best tier always carries its full table row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && link_tier == lap_pkg::TIER_BEST |->
         modulation == lap_pkg::MOD_OOK && sym_rate == lap_pkg::RATE_5M &&
         tx_power == 4'd2 && rx_gain == 3'd1)
      else $error("lap: best tier setting mismatch");

endmodule

bind link_adaptation_policy lap_checker u_lap_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .link_tier        (rsp_bus.link_tier),
   .modulation       (rsp_bus.modulation),
   .sym_rate         (rsp_bus.sym_rate),
   .tx_power         (rsp_bus.tx_power),
   .rx_gain          (rsp_bus.rx_gain),
   .detect_threshold (rsp_bus.detect_threshold)
);
